@@ src/iff_pkg.sv @@
// ----------------------------------------------------------------------------
// iff_pkg
// Types and constants shared by the information frame stuffing framer.
// ----------------------------------------------------------------------------
package iff_pkg;

  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] REG_FLAG       = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_ADDRESS    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_ESCAPE     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_FLAG_SUB   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_ESCAPE_SUB = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_CTRL_ZERO  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] REG_CTRL_ONE   = 3'd6;

  localparam logic [7:0] CHECK_INIT = 8'h00;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_FLAG,
    CLS_ESC
  } stuff_cls_t;

  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_BCC,
    PH_DATA,
    PH_DATA2,
    PH_CHK,
    PH_CHK2,
    PH_CLOSE
  } phase_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] address_value;
    logic [7:0] escape_value;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  typedef struct packed {
    logic       first;
    logic       seq;
    logic       last;
    logic [7:0] data;
    stuff_cls_t data_cls;
    logic [7:0] check;
    stuff_cls_t check_cls;
  } entry_t;

  function automatic stuff_cls_t classify(input logic [7:0] b, input cfg_t cfg);
    stuff_cls_t cls;
    if (b == cfg.flag_value) begin
      cls = CLS_FLAG;
    end else if (b == cfg.escape_value) begin
      cls = CLS_ESC;
    end else begin
      cls = CLS_PLAIN;
    end
    return cls;
  endfunction

endpackage

@@ src/iff_front.sv @@
// ----------------------------------------------------------------------------
// iff_front
// Accepts input items, keeps the running XOR check and classifies the
// payload and check bytes for stuffing.
// ----------------------------------------------------------------------------
module iff_front (
  input  logic            clk,
  input  logic            rst_n,
  input  iff_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_payload_byte,
  input  logic            in_sequence_bit,
  input  logic            in_first_of_packet,
  input  logic            in_last_of_packet,
  input  logic            q_full,
  output logic            q_push,
  output iff_pkg::entry_t q_entry
);
  import iff_pkg::*;

  logic [7:0] chk_r;
  logic [7:0] chk_nxt;
  logic [7:0] data_check;

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign data_check = (in_first_of_packet ? CHECK_INIT : chk_r) ^ in_payload_byte;
  assign chk_nxt    = in_last_of_packet ? CHECK_INIT : data_check;

  always_comb begin
    q_entry.first     = in_first_of_packet;
    q_entry.seq       = in_sequence_bit;
    q_entry.last      = in_last_of_packet;
    q_entry.data      = in_payload_byte;
    q_entry.data_cls  = classify(in_payload_byte, cfg);
    q_entry.check     = data_check;
    q_entry.check_cls = classify(data_check, cfg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= CHECK_INIT;
    end else if (q_push) begin
      chk_r <= chk_nxt;
    end
  end

endmodule

@@ src/iff_queue.sv @@
// ----------------------------------------------------------------------------
// iff_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module iff_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  iff_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output iff_pkg::entry_t head
);
  import iff_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ src/iff_back.sv @@
// ----------------------------------------------------------------------------
// iff_back
// Byte sequencer: walks header, stuffed payload, stuffed check and closing
// flag for the item at the queue head, one line byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module iff_back (
  input  logic            clk,
  input  logic            rst_n,
  input  iff_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  iff_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_line_byte,
  output logic            out_last_of_run,
  output logic            out_frame_done
);
  import iff_pkg::*;

  phase_t     phase_r;
  phase_t     phase_nxt;
  phase_t     cur;
  logic       busy_r;
  logic       fin;
  logic       load;
  logic [7:0] ctrl;
  logic [7:0] byte_c;
  logic       done_c;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && fin;
  assign cur  = busy_r ? phase_r : (head.first ? PH_FLAG : PH_DATA);
  assign ctrl = head.seq ? cfg.control_seq_one : cfg.control_seq_zero;

  // next phase
  always_comb begin
    phase_nxt = cur;
    fin       = 1'b0;
    unique case (cur)
      PH_FLAG:  phase_nxt = PH_ADDR;
      PH_ADDR:  phase_nxt = PH_CTRL;
      PH_CTRL:  phase_nxt = PH_BCC;
      PH_BCC:   phase_nxt = PH_DATA;
      PH_DATA: begin
        if (head.data_cls != CLS_PLAIN) begin
          phase_nxt = PH_DATA2;
        end else if (head.last) begin
          phase_nxt = PH_CHK;
        end else begin
          fin = 1'b1;
        end
      end
      PH_DATA2: begin
        if (head.last) begin
          phase_nxt = PH_CHK;
        end else begin
          fin = 1'b1;
        end
      end
      PH_CHK:   phase_nxt = (head.check_cls != CLS_PLAIN) ? PH_CHK2 : PH_CLOSE;
      PH_CHK2:  phase_nxt = PH_CLOSE;
      PH_CLOSE: fin = 1'b1;
      default:  fin = 1'b1;
    endcase
  end

  // byte for the current phase
  always_comb begin
    byte_c = cfg.flag_value;
    done_c = 1'b0;
    unique case (cur)
      PH_FLAG:  byte_c = cfg.flag_value;
      PH_ADDR:  byte_c = cfg.address_value;
      PH_CTRL:  byte_c = ctrl;
      PH_BCC:   byte_c = cfg.address_value ^ ctrl;
      PH_DATA:  byte_c = (head.data_cls == CLS_PLAIN) ? head.data : cfg.escape_value;
      PH_DATA2: byte_c = (head.data_cls == CLS_FLAG) ? cfg.flag_substitute
                                                     : cfg.escape_substitute;
      PH_CHK:   byte_c = (head.check_cls == CLS_PLAIN) ? head.check : cfg.escape_value;
      PH_CHK2:  byte_c = (head.check_cls == CLS_FLAG) ? cfg.flag_substitute
                                                      : cfg.escape_substitute;
      PH_CLOSE: begin
        byte_c = cfg.flag_value;
        done_c = 1'b1;
      end
      default:  byte_c = cfg.flag_value;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAG;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        phase_r <= phase_nxt;
        busy_r  <= !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_c;
      out_last_r <= fin;
      out_done_r <= done_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_byte   = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_frame_done  = out_done_r;

endmodule

@@ src/info_frame_stuffing_framer.sv @@
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer
// Frames payload bytes into information frames with byte stuffing and an
// XOR block check.
// ----------------------------------------------------------------------------
// Each input item yields 1 to 9 line bytes: header (flag, address, control,
// address XOR control) on a packet's first item, the payload byte stuffed
// with escape when it equals flag or escape, and on the last item the
// stuffed XOR check and a closing flag. The back sequencer emits one line
// byte per clock while an item is queued and the receiver does not stall
// it; the front takes one item per clock while the queue has room. Configure
// registers only while the block is idle.
module info_frame_stuffing_framer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [iff_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_payload_byte,
  input  logic                           in_sequence_bit,
  input  logic                           in_first_of_packet,
  input  logic                           in_last_of_packet,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_line_byte,
  output logic                           out_last_of_run,
  output logic                           out_frame_done
);
  import iff_pkg::*;

  cfg_t   cfg_r;
  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   head_valid;
  entry_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value        <= 8'h7E;
      cfg_r.address_value     <= 8'h03;
      cfg_r.escape_value      <= 8'h7D;
      cfg_r.flag_substitute   <= 8'h5E;
      cfg_r.escape_substitute <= 8'h5D;
      cfg_r.control_seq_zero  <= 8'h00;
      cfg_r.control_seq_one   <= 8'h40;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FLAG:       cfg_r.flag_value        <= cfg_data;
        REG_ADDRESS:    cfg_r.address_value     <= cfg_data;
        REG_ESCAPE:     cfg_r.escape_value      <= cfg_data;
        REG_FLAG_SUB:   cfg_r.flag_substitute   <= cfg_data;
        REG_ESCAPE_SUB: cfg_r.escape_substitute <= cfg_data;
        REG_CTRL_ZERO:  cfg_r.control_seq_zero  <= cfg_data;
        REG_CTRL_ONE:   cfg_r.control_seq_one   <= cfg_data;
        default: ;
      endcase
    end
  end

  iff_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_payload_byte    (in_payload_byte),
    .in_sequence_bit    (in_sequence_bit),
    .in_first_of_packet (in_first_of_packet),
    .in_last_of_packet  (in_last_of_packet),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_entry            (q_entry)
  );

  iff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  iff_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_byte   (out_line_byte),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule

@@ bench/framer_line_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framer_line_checker
// Predicts the framed line bytes and compares them with the block output.
// ----------------------------------------------------------------------------
// Keeps a shadow copy of the configuration registers and of the running XOR
// check. Each accepted input item is expanded into its expected line bytes:
// header if first, stuffed payload, stuffed check and closing flag if last.
// Every accepted output item is matched field by field against the oldest.
// ----------------------------------------------------------------------------
module framer_line_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [iff_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_payload_byte,
  input  logic                            in_sequence_bit,
  input  logic                            in_first_of_packet,
  input  logic                            in_last_of_packet,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_line_byte,
  input  logic                            out_last_of_run,
  input  logic                            out_frame_done,
  output int unsigned                     fail_count,
  output int unsigned                     pending_count
);
  import iff_pkg::*;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_of_run;
    logic       frame_done;
  } line_item_t;

  localparam cfg_t CFG_AT_RESET = '{
    flag_value:        8'h7E,
    address_value:     8'h03,
    escape_value:      8'h7D,
    flag_substitute:   8'h5E,
    escape_substitute: 8'h5D,
    control_seq_zero:  8'h00,
    control_seq_one:   8'h40
  };

  cfg_t        shadow_cfg;
  logic [7:0]  payload_xor;
  line_item_t  line_due[$];
  int unsigned mismatches = 0;

  task automatic queue_byte(input logic [7:0] b, input logic done);
    line_item_t it;
    it.line_byte   = b;
    it.last_of_run = 1'b0;
    it.frame_done  = done;
    line_due.push_back(it);
  endtask

  task automatic queue_stuffed(input logic [7:0] b);
    if (b == shadow_cfg.flag_value) begin
      queue_byte(shadow_cfg.escape_value, 1'b0);
      queue_byte(shadow_cfg.flag_substitute, 1'b0);
    end else if (b == shadow_cfg.escape_value) begin
      queue_byte(shadow_cfg.escape_value, 1'b0);
      queue_byte(shadow_cfg.escape_substitute, 1'b0);
    end else begin
      queue_byte(b, 1'b0);
    end
  endtask

  task automatic expand_item(input logic [7:0] payload, input logic seq,
                             input logic first, input logic last);
    logic [7:0] ctrl;
    line_item_t tail;
    ctrl = seq ? shadow_cfg.control_seq_one : shadow_cfg.control_seq_zero;
    if (first) begin
      payload_xor = CHECK_INIT;
      queue_byte(shadow_cfg.flag_value, 1'b0);
      queue_byte(shadow_cfg.address_value, 1'b0);
      queue_byte(ctrl, 1'b0);
      queue_byte(shadow_cfg.address_value ^ ctrl, 1'b0);
    end
    queue_stuffed(payload);
    payload_xor = payload_xor ^ payload;
    if (last) begin
      queue_stuffed(payload_xor);
      queue_byte(shadow_cfg.flag_value, 1'b1);
      payload_xor = CHECK_INIT;
    end
    tail = line_due.pop_back();
    tail.last_of_run = 1'b1;
    line_due.push_back(tail);
  endtask

  always @(posedge clk) begin
    line_item_t want;
    if (!rst_n) begin
      shadow_cfg  = CFG_AT_RESET;
      payload_xor = CHECK_INIT;
      line_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FLAG:       shadow_cfg.flag_value        = cfg_data;
          REG_ADDRESS:    shadow_cfg.address_value     = cfg_data;
          REG_ESCAPE:     shadow_cfg.escape_value      = cfg_data;
          REG_FLAG_SUB:   shadow_cfg.flag_substitute   = cfg_data;
          REG_ESCAPE_SUB: shadow_cfg.escape_substitute = cfg_data;
          REG_CTRL_ZERO:  shadow_cfg.control_seq_zero  = cfg_data;
          REG_CTRL_ONE:   shadow_cfg.control_seq_one   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expand_item(in_payload_byte, in_sequence_bit, in_first_of_packet,
                    in_last_of_packet);
      end
      if (out_valid && !out_stall) begin
        if (line_due.size() == 0) begin
          $error("line byte %h arrived with nothing expected", out_line_byte);
          mismatches++;
        end else begin
          want = line_due.pop_front();
          if (out_line_byte !== want.line_byte) begin
            $error("line_byte: expected %h, actual %h", want.line_byte, out_line_byte);
            mismatches++;
          end
          if (out_last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last_of_run,
                   out_last_of_run);
            mismatches++;
          end
          if (out_frame_done !== want.frame_done) begin
            $error("frame_done: expected %b, actual %b", want.frame_done,
                   out_frame_done);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= line_due.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the information frame stuffing framer.
// ----------------------------------------------------------------------------
// Drives directed packets that hit the stuffing and check-byte corner cases,
// then random packets under several register settings and idle patterns,
// including a long receiver hold-off that backs up the input. The line
// checker beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_top;
  import iff_pkg::*;

  localparam int unsigned RunLimit      = 200000;
  localparam int unsigned ItemsPerPhase = 80;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned TailCycles    = 12;

  localparam cfg_t CFG_AT_RESET = '{
    flag_value:        8'h7E,
    address_value:     8'h03,
    escape_value:      8'h7D,
    flag_substitute:   8'h5E,
    escape_substitute: 8'h5D,
    control_seq_zero:  8'h00,
    control_seq_one:   8'h40
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [7:0]             cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_payload_byte;
  logic                   in_sequence_bit;
  logic                   in_first_of_packet;
  logic                   in_last_of_packet;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_line_byte;
  logic                   out_last_of_run;
  logic                   out_frame_done;
  int unsigned            fail_count;
  int unsigned            pending_count;

  int unsigned cycle_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_go      = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = HoldCycles;
  cfg_t        cur_cfg;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  info_frame_stuffing_framer u_top (.*);

  framer_line_checker u_checker (.*);

  // receiver: one long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
      if (hold_left == 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_FLAG, c.flag_value);
    write_reg(REG_ADDRESS, c.address_value);
    write_reg(REG_ESCAPE, c.escape_value);
    write_reg(REG_FLAG_SUB, c.flag_substitute);
    write_reg(REG_ESCAPE_SUB, c.escape_substitute);
    write_reg(REG_CTRL_ZERO, c.control_seq_zero);
    write_reg(REG_CTRL_ONE, c.control_seq_one);
    cfg_wr_en <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // returns right after the edge that accepted the item, valid still high
  task automatic offer_item(input logic [7:0] payload, input logic seq,
                            input logic first, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_payload_byte    <= payload;
    in_sequence_bit    <= seq;
    in_first_of_packet <= first;
    in_last_of_packet  <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(5))
      0:       b = cur_cfg.flag_value;
      1:       b = cur_cfg.escape_value;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // mostly well-formed packets; the last byte often steers the check onto
  // the flag or escape value; the rest are items with random markers
  task automatic random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    logic [7:0]  acc;
    logic [7:0]  b;
    logic        seq;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) < 8) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
        seq = 1'($urandom_range(1));
        acc = CHECK_INIT;
        for (k = 0; k < len; k++) begin
          b = pick_byte();
          if (k == len - 1) begin
            case ($urandom_range(5))
              0:       b = acc ^ cur_cfg.flag_value;
              1:       b = acc ^ cur_cfg.escape_value;
              default: ;
            endcase
          end
          acc = acc ^ b;
          offer_item(b, seq, k == 0, k == len - 1);
        end
        sent += len;
      end else begin
        offer_item(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    cfg_t rnd_cfg;
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= REG_FLAG;
    cfg_data           <= 8'h00;
    in_valid           <= 1'b0;
    in_payload_byte    <= 8'h00;
    in_sequence_bit    <= 1'b0;
    in_first_of_packet <= 1'b0;
    in_last_of_packet  <= 1'b0;
    cur_cfg = CFG_AT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte packets holding a flag and an escape, then a longer packet with both
    offer_item(8'h7E, 1'b0, 1'b1, 1'b1);
    offer_item(8'h7D, 1'b1, 1'b1, 1'b1);
    offer_item(8'h00, 1'b0, 1'b1, 1'b0);
    offer_item(8'hFF, 1'b0, 1'b0, 1'b0);
    offer_item(8'h7E, 1'b0, 1'b0, 1'b0);
    offer_item(8'h7D, 1'b0, 1'b0, 1'b1);
    // bytes after a closed frame with no packet start
    offer_item(8'h55, 1'b0, 1'b0, 1'b0);
    offer_item(8'hAA, 1'b1, 1'b0, 1'b1);
    // check byte lands on flag, then on escape
    offer_item(8'h01, 1'b0, 1'b1, 1'b0);
    offer_item(8'h7F, 1'b0, 1'b0, 1'b1);
    offer_item(8'h70, 1'b1, 1'b1, 1'b0);
    offer_item(8'h0D, 1'b1, 1'b0, 1'b1);
    // packet restarted before its end clears the check
    offer_item(8'h12, 1'b0, 1'b1, 1'b0);
    offer_item(8'h34, 1'b1, 1'b1, 1'b1);

    // flag and escape share one value
    drain_block();
    load_config('{8'h55, 8'h00, 8'h55, 8'hFF, 8'hAA, 8'hFF, 8'h00});
    offer_item(8'h55, 1'b1, 1'b1, 1'b1);
    offer_item(8'h55, 1'b0, 1'b1, 1'b0);
    offer_item(8'h00, 1'b0, 1'b0, 1'b0);
    offer_item(8'hAA, 1'b0, 1'b0, 1'b1);

    drain_block();
    load_config('{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    tx_idle_pct = 22;
    rx_stall_pct <= 77;
    random_phase(ItemsPerPhase);

    drain_block();
    rnd_cfg = 56'({$urandom(), $urandom()});
    load_config(rnd_cfg);
    tx_idle_pct = 77;
    rx_stall_pct <= 22;
    random_phase(ItemsPerPhase);

    drain_block();
    load_config(CFG_AT_RESET);
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_go <= 1'b1;
    random_phase(ItemsPerPhase);

    drain_block();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
